// File: src/pdm_pkg.sv
package pdm_pkg;

  localparam int CH_W       = 2;
  localparam int TS_W       = 16;
  localparam int DUTY_W     = 14;
  localparam int DIVIDEND_W = 30;
  localparam int DIVISOR_W  = 16;
  localparam int QCNT_W     = 4;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  localparam logic [DUTY_W-1:0] DUTY_SCALE = 14'd10000;

  typedef enum logic {
    EDGE_FALL = 1'b0,
    EDGE_RISE = 1'b1
  } edge_kind_t;

  typedef struct packed {
    edge_kind_t            kind;
    logic [CH_W-1:0]       channel;
    logic [TS_W-1:0]       timestamp;
  } cmd_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [DUTY_W-1:0]     quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_DUTY_GO,
    BK_DUTY_WAIT,
    BK_AVG,
    BK_EMIT
  } back_state_t;

endpackage

// File: src/pwm_duty_meter_averaged_top.sv
// Channel  Dir  Handshake            Payload
// in_      in   in_tvalid/in_tready  tdata: channel, timestamp; tuser: level
// out_     out  out_tvalid/out_tready tdata: result_channel, duty_average;
//                                     tuser: sample_taken
//
// A falling edge stays in BK_IDLE, a skipped rising edge goes to BK_EMIT; a stored
// one passes BK_MUL, BK_DUTY_GO, BK_DUTY_WAIT (the 14-step duty-ratio divider),
// BK_AVG (one reciprocal multiplication) and BK_EMIT. Reset is synchronous, active
// low and clears all channel registers; the ring memory needs no clearing pass, as
// stale entries count only after a wrap. A two-entry queue decouples input from
// the back end; the output register lets it keep filling while a result waits.
module pwm_duty_meter_averaged_top #(
  parameter int CHANNELS   = 4,
  parameter int AVG_POINTS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [1:0] channel, [17:2] timestamp, [23:18] zero
  input  logic [pdm_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [0] level
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [1:0] result_channel, [15:2] duty_average
  output logic [pdm_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [0] sample_taken
  output logic                             out_tuser
);

  logic              cmd_valid;
  pdm_pkg::cmd_t     cmd;
  logic              cmd_pop;
  pdm_pkg::div_req_t div_req;
  pdm_pkg::div_rsp_t div_rsp;

  pdm_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  pdm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  pdm_back #(
    .CHANNELS   (CHANNELS),
    .AVG_POINTS (AVG_POINTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_full_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> cmd_valid)
    else $error("input stalled with an empty queue");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |=> !div_rsp.done)
    else $error("divider done held for more than one cycle");

endmodule

// File: src/pdm_front.sv
module pdm_front #(
  parameter int CHANNELS = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [pdm_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             in_tuser,
  output logic                             cmd_valid,
  output pdm_pkg::cmd_t                    cmd,
  input  logic                             cmd_pop
);

  pdm_pkg::cmd_t q_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    count_r;
  logic          in_range;
  logic          push;
  logic          pop;
  pdm_pkg::cmd_t entry;

  assign in_range  = {30'd0, in_tdata[1:0]} < 32'(CHANNELS);
  assign in_tready = (count_r != 2'd2);
  assign push      = in_tvalid && in_tready && in_range;
  assign cmd_valid = (count_r != 2'd0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    entry.kind      = pdm_pkg::edge_kind_t'(in_tuser);
    entry.channel   = in_tdata[pdm_pkg::CH_W-1:0];
    entry.timestamp = in_tdata[pdm_pkg::CH_W+pdm_pkg::TS_W-1:pdm_pkg::CH_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= 2'(count_r + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= entry;
    end
  end

endmodule

// File: src/pdm_div.sv
module pdm_div (
  input  logic              clk,
  input  logic              rst_n,
  input  pdm_pkg::div_req_t req,
  output pdm_pkg::div_rsp_t rsp
);

  logic [pdm_pkg::DIVISOR_W-1:0] rem_r;
  logic [pdm_pkg::DIVISOR_W-1:0] divisor_r;
  logic [pdm_pkg::DUTY_W-1:0]    low_r;
  logic [pdm_pkg::DUTY_W-1:0]    q_r;
  logic [pdm_pkg::QCNT_W-1:0]    cnt_r;
  logic                          busy_r;
  logic                          done_r;
  logic [pdm_pkg::DIVISOR_W:0]   trial;
  logic [pdm_pkg::DIVISOR_W:0]   diff;
  logic                          qbit;

  assign trial = {rem_r, low_r[pdm_pkg::DUTY_W-1]};
  assign diff  = trial - {1'b0, divisor_r};
  assign qbit  = (trial >= {1'b0, divisor_r});

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= pdm_pkg::QCNT_W'(pdm_pkg::DUTY_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      rem_r     <= req.dividend[pdm_pkg::DIVIDEND_W-1:pdm_pkg::DUTY_W];
      low_r     <= req.dividend[pdm_pkg::DUTY_W-1:0];
      divisor_r <= req.divisor;
      q_r       <= '0;
    end else if (busy_r) begin
      rem_r <= qbit ? diff[pdm_pkg::DIVISOR_W-1:0] : trial[pdm_pkg::DIVISOR_W-1:0];
      low_r <= {low_r[pdm_pkg::DUTY_W-2:0], 1'b0};
      q_r   <= {q_r[pdm_pkg::DUTY_W-2:0], qbit};
    end
  end

endmodule

// File: src/pdm_back.sv
module pdm_back #(
  parameter int CHANNELS   = 4,
  parameter int AVG_POINTS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cmd_valid,
  input  pdm_pkg::cmd_t                    cmd,
  output logic                             cmd_pop,
  output pdm_pkg::div_req_t                div_req,
  input  pdm_pkg::div_rsp_t                div_rsp,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pdm_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tuser
);

  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW    = (AVG_POINTS > 1) ? $clog2(AVG_POINTS) : 1;
  localparam int DEPTH = CHANNELS * AVG_POINTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W = pdm_pkg::DUTY_W + $clog2(AVG_POINTS + 1);

  // The ring average is the running sum times a rounded-up reciprocal of
  // AVG_POINTS, shifted down; the shift leaves the quotient exact for every sum.
  localparam int AVG_SH  = SUM_W + PW;
  localparam int RECIP_W = AVG_SH + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] AVG_RECIP =
    RECIP_W'(((64'd1 << AVG_SH) + 64'(AVG_POINTS) - 64'd1) / 64'(AVG_POINTS));

  pdm_pkg::back_state_t state_r, state_nxt;

  logic [pdm_pkg::TS_W-1:0]   period_start_r [CHANNELS];
  logic [pdm_pkg::TS_W-1:0]   low_start_r    [CHANNELS];
  logic [PW-1:0]              ring_pos_r     [CHANNELS];
  logic [SUM_W-1:0]           sum_r          [CHANNELS];
  logic [pdm_pkg::DUTY_W-1:0] avg_r          [CHANNELS];
  logic [CHANNELS-1:0]        wrapped_r;

  logic [pdm_pkg::DUTY_W-1:0] ring_mem [DEPTH];
  logic [pdm_pkg::DUTY_W-1:0] mem_q_r;

  logic [pdm_pkg::CH_W-1:0]       ch_r;
  logic [CW-1:0]                  cidx_r;
  logic [pdm_pkg::TS_W-1:0]       now_r;
  logic [pdm_pkg::TS_W-1:0]       high_r;
  logic [pdm_pkg::TS_W-1:0]       period_r;
  logic                           take_r;
  logic [AW-1:0]                  addr_r;
  logic [pdm_pkg::DIVIDEND_W-1:0] prod_r;
  logic [pdm_pkg::DUTY_W-1:0]     old_r;

  logic                           out_valid_r;
  logic [pdm_pkg::CH_W-1:0]       out_ch_r;
  logic [pdm_pkg::DUTY_W-1:0]     out_avg_r;
  logic                           out_taken_r;

  logic [CW-1:0]              cidx;
  logic [pdm_pkg::TS_W-1:0]   start_ts;
  logic [pdm_pkg::TS_W-1:0]   fall_ts;
  logic                       take;
  logic [AW-1:0]              rd_addr;
  logic [pdm_pkg::DUTY_W-1:0] duty_sat;
  logic [SUM_W-1:0]           sum_new;
  logic [PROD_W-1:0]          avg_prod;
  logic [PW-1:0]              pos_cur;
  logic                       pos_last;
  logic [PW-1:0]              pos_next;
  logic                       rise_pop;
  logic                       fall_pop;
  logic                       duty_done;
  logic                       avg_done;
  logic                       out_load;

  assign cidx     = CW'(cmd.channel);
  assign start_ts = period_start_r[cidx];
  assign fall_ts  = low_start_r[cidx];
  assign take     = (start_ts <= fall_ts) && (fall_ts <= cmd.timestamp) &&
                    (cmd.timestamp != start_ts);
  assign rd_addr  = AW'(32'(cidx) * AVG_POINTS + 32'(ring_pos_r[cidx]));

  assign duty_sat = (div_rsp.quotient > pdm_pkg::DUTY_SCALE) ? pdm_pkg::DUTY_SCALE
                                                              : div_rsp.quotient;
  assign sum_new  = sum_r[cidx_r] + SUM_W'(duty_sat) - SUM_W'(old_r);
  assign avg_prod = PROD_W'(sum_r[cidx_r]) * PROD_W'(AVG_RECIP);
  assign pos_cur  = ring_pos_r[cidx_r];
  assign pos_last = (32'(pos_cur) == AVG_POINTS - 1);
  assign pos_next = pos_last ? '0 : PW'(32'(pos_cur) + 1);

  assign rise_pop  = cmd_pop && (cmd.kind == pdm_pkg::EDGE_RISE);
  assign fall_pop  = cmd_pop && (cmd.kind == pdm_pkg::EDGE_FALL);
  assign duty_done = (state_r == pdm_pkg::BK_DUTY_WAIT) && div_rsp.done;
  assign avg_done  = (state_r == pdm_pkg::BK_AVG);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pdm_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    cmd_pop          = 1'b0;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = prod_r;
    div_req.divisor  = period_r;
    unique case (state_r)
      pdm_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.kind == pdm_pkg::EDGE_RISE) begin
            state_nxt = take ? pdm_pkg::BK_MUL : pdm_pkg::BK_EMIT;
          end
        end
      end
      pdm_pkg::BK_MUL: begin
        state_nxt = pdm_pkg::BK_DUTY_GO;
      end
      pdm_pkg::BK_DUTY_GO: begin
        div_req.start = 1'b1;
        state_nxt     = pdm_pkg::BK_DUTY_WAIT;
      end
      pdm_pkg::BK_DUTY_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = pdm_pkg::BK_AVG;
        end
      end
      pdm_pkg::BK_AVG: begin
        state_nxt = pdm_pkg::BK_EMIT;
      end
      pdm_pkg::BK_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = pdm_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = pdm_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        period_start_r[c] <= '0;
        low_start_r[c]    <= '0;
        ring_pos_r[c]     <= '0;
        sum_r[c]          <= '0;
        avg_r[c]          <= '0;
      end
      wrapped_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fall_pop) begin
        low_start_r[cidx] <= cmd.timestamp;
      end
      if (duty_done) begin
        sum_r[cidx_r]          <= sum_new;
        ring_pos_r[cidx_r]     <= pos_next;
        period_start_r[cidx_r] <= now_r;
        if (pos_last) begin
          wrapped_r[cidx_r] <= 1'b1;
        end
      end
      if (avg_done) begin
        avg_r[cidx_r] <= avg_prod[AVG_SH +: pdm_pkg::DUTY_W];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rise_pop) begin
      ch_r     <= cmd.channel;
      cidx_r   <= cidx;
      now_r    <= cmd.timestamp;
      high_r   <= fall_ts - start_ts;
      period_r <= cmd.timestamp - start_ts;
      take_r   <= take;
      addr_r   <= rd_addr;
    end
    if (state_r == pdm_pkg::BK_MUL) begin
      prod_r <= {14'd0, high_r} * {16'd0, pdm_pkg::DUTY_SCALE};
      old_r  <= wrapped_r[cidx_r] ? mem_q_r : '0;
    end
    if (out_load) begin
      out_ch_r    <= ch_r;
      out_avg_r   <= avg_r[cidx_r];
      out_taken_r <= take_r;
    end
  end

  always_ff @(posedge clk) begin
    if (duty_done) begin
      ring_mem[addr_r] <= duty_sat;
    end
    mem_q_r <= ring_mem[rd_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_avg_r, out_ch_r};
  assign out_tuser  = out_taken_r;

endmodule

// File: tb/pwm_duty_meter_averaged_top_test.sv
`timescale 1ns / 1ps

typedef struct {
  logic [1:0]  channel;
  logic [13:0] duty_average;
  logic        sample_taken;
} duty_result_t;

class duty_scoreboard;
  localparam int LINES      = 4;
  localparam int RING_DEPTH = 8;

  logic [15:0]  rise_time [LINES];
  logic [15:0]  fall_time [LINES];
  logic [13:0]  ring      [LINES][RING_DEPTH];
  int unsigned  slot      [LINES];
  logic [13:0]  mean      [LINES];
  duty_result_t pending_duty[$];
  int           errors;
  int           results_seen;

  function new();
    for (int c = 0; c < LINES; c++) begin
      rise_time[c] = '0;
      fall_time[c] = '0;
      slot[c]      = 0;
      mean[c]      = '0;
      for (int k = 0; k < RING_DEPTH; k++) begin
        ring[c][k] = '0;
      end
    end
    errors       = 0;
    results_seen = 0;
  endfunction

  task report(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  // Falling edges only mark the start of the low phase; every rising edge
  // yields one result, whether or not its sample is stored.
  function void note_edge(logic [1:0] ch, pdm_pkg::edge_kind_t kind, logic [15:0] ts);
    int unsigned  high_ticks;
    int unsigned  span;
    int unsigned  duty;
    int unsigned  total;
    bit           take;
    duty_result_t res;
    if (kind == pdm_pkg::EDGE_FALL) begin
      fall_time[ch] = ts;
      return;
    end
    take = !(rise_time[ch] > fall_time[ch] || fall_time[ch] > ts || ts == rise_time[ch]);
    if (take) begin
      high_ticks = fall_time[ch] - rise_time[ch];
      span       = ts - rise_time[ch];
      duty       = (high_ticks * pdm_pkg::DUTY_SCALE) / span;
      if (duty > pdm_pkg::DUTY_SCALE) begin
        duty = pdm_pkg::DUTY_SCALE;
      end
      ring[ch][slot[ch]] = duty[13:0];
      slot[ch] = (slot[ch] + 1) % RING_DEPTH;
      total = 0;
      for (int k = 0; k < RING_DEPTH; k++) begin
        total += ring[ch][k];
      end
      mean[ch]      = 14'(total / RING_DEPTH);
      rise_time[ch] = ts;
    end
    res.channel      = ch;
    res.duty_average = mean[ch];
    res.sample_taken = take;
    pending_duty.push_back(res);
  endfunction

  task check_result(logic [15:0] data, logic flag);
    duty_result_t want;
    results_seen++;
    if (pending_duty.size() == 0) begin
      report($sformatf("unexpected beat ch=%0d avg=%0d taken=%0b", data[1:0], data[15:2], flag));
      return;
    end
    want = pending_duty.pop_front();
    if (data[1:0] !== want.channel) begin
      report($sformatf("channel %0d, wanted %0d", data[1:0], want.channel));
    end
    if (data[15:2] !== want.duty_average) begin
      report($sformatf("ch %0d average %0d, wanted %0d", want.channel, data[15:2],
                       want.duty_average));
    end
    if (flag !== want.sample_taken) begin
      report($sformatf("ch %0d sample_taken %0b, wanted %0b", want.channel, flag,
                       want.sample_taken));
    end
  endtask
endclass

module pwm_duty_meter_averaged_top_test;
  localparam int IN_W  = pdm_pkg::IN_TDATA_W;
  localparam int OUT_W = pdm_pkg::OUT_TDATA_W;
  localparam int RANDOM_ITEMS = 450;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             in_tuser;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tuser;

  duty_scoreboard sb = new();
  bit             calm;
  int             sent;

  pwm_duty_meter_averaged_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  task send_edge(logic [1:0] ch, pdm_pkg::edge_kind_t kind, logic [15:0] ts);
    while (!calm && $urandom_range(99) < 34) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = IN_W'({ts, ch});
    in_tuser  = kind;
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    sb.note_edge(ch, kind, ts);
    sent++;
    @(negedge clk);
  endtask

  task send_period(logic [1:0] ch, logic [15:0] fall_ts, logic [15:0] rise_ts);
    send_edge(ch, pdm_pkg::EDGE_FALL, fall_ts);
    send_edge(ch, pdm_pkg::EDGE_RISE, rise_ts);
  endtask

  task random_item();
    logic [1:0]  ch;
    int unsigned base;
    int unsigned room;
    int unsigned span;
    int unsigned high_ticks;
    int unsigned pick;
    ch   = 2'($urandom_range(3));
    base = sb.rise_time[ch];
    room = 65535 - base;
    pick = $urandom_range(99);
    span = ($urandom_range(9) == 0) ? $urandom_range(1, 2000) : $urandom_range(1, 200);
    if (span > room) begin
      span = room;
    end
    if (pick < 70 && room >= 2) begin
      case ($urandom_range(9))
        0: high_ticks = 0;
        1: high_ticks = span;
        default: high_ticks = $urandom_range(span);
      endcase
      send_period(ch, 16'(base + high_ticks), 16'(base + span));
    end else if (pick < 80 && room >= 2) begin
      send_edge(ch, pdm_pkg::EDGE_RISE, 16'(base + $urandom_range(span)));
    end else if (pick < 88 && room >= 2) begin
      send_period(ch, 16'(base + span), 16'(base + $urandom_range(span - 1)));
    end else begin
      send_edge(2'($urandom_range(3)), pdm_pkg::edge_kind_t'($urandom_range(1)),
                16'($urandom));
    end
  endtask

  initial begin
    int hold_left;
    bit held_once;
    hold_left  = 0;
    held_once  = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n && !held_once && sb.results_seen >= 40) begin
        hold_left = 400;
        held_once = 1'b1;
      end
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        out_tready = calm || $urandom_range(99) >= 34;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        sb.check_result(out_tdata, out_tuser);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int drain;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    calm      = 1'b0;
    sent      = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Zero period after reset, ordinary, zero-high, full-high, repeat and early rises.
    send_edge(2'd0, pdm_pkg::EDGE_RISE, 16'd0);
    send_period(2'd0, 16'd300, 16'd1000);
    send_period(2'd0, 16'd1000, 16'd2000);
    send_period(2'd0, 16'd2500, 16'd2500);
    send_edge(2'd0, pdm_pkg::EDGE_RISE, 16'd2500);
    send_edge(2'd0, pdm_pkg::EDGE_RISE, 16'd2400);
    // Rollover of the tick counter makes the rising edge arrive out of order.
    send_period(2'd1, 16'h8000, 16'hC000);
    send_period(2'd1, 16'h0010, 16'h0020);
    send_period(2'd2, 16'h5555, 16'hAAAA);
    send_period(2'd2, 16'hAAAA, 16'hAAAB);
    send_period(2'd3, 16'h1555, 16'h2AAA);
    send_edge(2'd3, pdm_pkg::EDGE_RISE, 16'hFFFF);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = (sent >= 150 && sent < 260);
      random_item();
    end
    calm      = 1'b0;
    in_tvalid = 1'b0;

    drain = 0;
    while (sb.pending_duty.size() != 0 && drain < 200000) begin
      @(posedge clk);
      drain++;
    end
    repeat (100) @(posedge clk);
    if (sb.pending_duty.size() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.pending_duty.size()));
    end
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// File: pwm_duty_meter_averaged_top.f
src/pdm_pkg.sv
src/pdm_front.sv
src/pdm_div.sv
src/pdm_back.sv
src/pwm_duty_meter_averaged_top.sv
tb/pwm_duty_meter_averaged_top_test.sv
